// ===== sv/pph_pkg.sv =====
`default_nettype none

package pph_pkg;

  // Bins per plane, one for each 8-bit pixel value.
  localparam int BINS = 256;

  localparam int REQ_W   = 2;
  localparam int PLANE_W = 2;
  localparam int LEVEL_W = 8;
  localparam int OUT_W   = 24;

  localparam int PLANES_DEF     = 4;
  localparam int COUNT_BITS_DEF = 24;

  // Request kinds carried on the input tuser.
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // One read result waiting in the output queue.
  typedef struct packed {
    logic             saturated;
    logic [OUT_W-1:0] bin_count;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/pph_ram.sv =====
`default_nettype none

module pph_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/per_plane_pixel_histogram_core.sv =====
// Per-plane pixel histogram: PLANES histograms of 256 saturating counters each.
// Requests arrive on the slave stream. tuser carries the request kind (count,
// read or clear); tdata carries the plane index and the 8-bit level. A count
// beat increments one bin, a clear beat zeroes every bin of every plane, and a
// read beat returns one bin on the master stream: tdata holds the count and
// tuser flags a counter that has reached its maximum.
// Count beats are taken one per cycle while no clear runs and the output queue
// has room. Back-to-back read beats are held off at times, as the ready check
// does not count on a pop. The counters live in a single memory with a
// registered read, so each beat reads in the cycle it is taken and writes back
// in the next. A write to the same bin one beat earlier is forwarded. A read
// result passes through the write-back stage and the output queue before it
// can be taken on the master side. The two-entry output queue lets requests
// keep flowing while the receiver stalls. Apart from a clear, the block holds
// off new beats only when that queue could overflow. A clear walks the memory
// one entry per cycle, PLANES*256 entries, with tready low. Reset starts the
// same clearing pass, so the block takes no beat until that pass is done.
`default_nettype none

module per_plane_pixel_histogram_core #(
  parameter int PLANES     = pph_pkg::PLANES_DEF,
  parameter int COUNT_BITS = pph_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: plane [1:0], level [9:2], zeros above.
  input  wire logic [15:0] s_axis_tdata,
  // tuser: req_type [1:0].
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: bin_count [23:0].
  output logic      [23:0] m_axis_tdata,
  // tuser: saturated [0].
  output logic      [0:0]  m_axis_tuser
);
  import pph_pkg::*;

  localparam int DEPTH  = PLANES * BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Input fields.
  logic [REQ_W-1:0]   in_req;
  logic [PLANE_W-1:0] in_plane;
  logic [LEVEL_W-1:0] in_level;
  logic               in_ok;
  logic [ADDR_W-1:0]  in_addr;
  logic               in_acc;

  assign in_req   = s_axis_tuser;
  assign in_plane = s_axis_tdata[PLANE_W-1:0];
  assign in_level = s_axis_tdata[PLANE_W+LEVEL_W-1:PLANE_W];
  assign in_ok    = int'(in_plane) < PLANES;
  assign in_addr  = ADDR_W'({in_plane, in_level});

  // Clearing pass.
  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  // Write-back stage: the beat whose memory data returns this cycle.
  logic              p1_valid_q, p1_valid_d;
  logic              p1_read_q, p1_read_d;
  logic              p1_ok_q, p1_ok_d;
  logic [ADDR_W-1:0] p1_addr_q, p1_addr_d;

  // Last write, forwarded to a read of the same entry in the following cycle.
  logic                  lw_valid_q, lw_valid_d;
  logic [ADDR_W-1:0]     lw_addr_q, lw_addr_d;
  logic [COUNT_BITS-1:0] lw_data_q, lw_data_d;

  // Output queue.
  out_item_t  oq_q [2];
  out_item_t  oq_push_item;
  logic       oq_wptr_q, oq_rptr_q;
  logic [1:0] oq_cnt_q, oq_cnt_d;
  logic       oq_push, oq_pop;

  // Memory port signals.
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic [COUNT_BITS-1:0] cur_count;
  logic                  inc_en;
  logic                  p1_is_read;

  pph_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(DEPTH)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(in_addr),
    .rdata_o(ram_rdata)
  );

  // Hold off a new beat when a read result could find the queue full: the
  // queue plus a read in flight must leave room for one more.
  assign p1_is_read    = p1_valid_q && p1_read_q;
  assign s_axis_tready = !clr_busy_q && ((oq_cnt_q + 2'(p1_is_read)) < 2'd2);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    p1_valid_d = 1'b0;
    p1_read_d  = 1'b0;
    p1_ok_d    = in_ok;
    p1_addr_d  = in_addr;
    if (in_acc) begin
      case (in_req)
        REQ_COUNT: begin
          p1_valid_d = in_ok;
        end
        REQ_READ: begin
          p1_valid_d = 1'b1;
          p1_read_d  = 1'b1;
        end
        default: begin
          p1_valid_d = 1'b0;
        end
      endcase
    end
  end

  // Read-modify-write of the counter.
  assign cur_count = (lw_valid_q && (lw_addr_q == p1_addr_q)) ? lw_data_q : ram_rdata;
  assign inc_en    = p1_valid_q && !p1_read_q && (cur_count != CNT_MAX);

  // The clearing pass never overlaps a write-back: no beat is taken while it runs.
  assign ram_we    = clr_busy_q || inc_en;
  assign ram_waddr = clr_busy_q ? clr_addr_q : p1_addr_q;
  assign ram_wdata = clr_busy_q ? '0 : (cur_count + COUNT_BITS'(1));

  assign lw_valid_d = inc_en;
  assign lw_addr_d  = p1_addr_q;
  assign lw_data_d  = cur_count + COUNT_BITS'(1);

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
        clr_addr_d = '0;
      end
    end else if (in_acc && (in_req == REQ_CLEAR)) begin
      clr_busy_d = 1'b1;
      clr_addr_d = '0;
    end
  end

  // A read of a plane that does not exist returns zero.
  assign oq_push                = p1_is_read;
  assign oq_push_item.bin_count = p1_ok_q ? OUT_W'(cur_count) : '0;
  assign oq_push_item.saturated = p1_ok_q && (cur_count == CNT_MAX);
  assign oq_pop                 = m_axis_tvalid && m_axis_tready;
  assign oq_cnt_d               = oq_cnt_q + 2'(oq_push) - 2'(oq_pop);

  assign m_axis_tvalid   = (oq_cnt_q != 2'd0);
  assign m_axis_tdata    = oq_q[oq_rptr_q].bin_count;
  assign m_axis_tuser[0] = oq_q[oq_rptr_q].saturated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      p1_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
      oq_wptr_q  <= 1'b0;
      oq_rptr_q  <= 1'b0;
      oq_cnt_q   <= 2'd0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
      p1_valid_q <= p1_valid_d;
      lw_valid_q <= lw_valid_d;
      oq_cnt_q   <= oq_cnt_d;
      if (oq_push) begin
        oq_wptr_q <= !oq_wptr_q;
      end
      if (oq_pop) begin
        oq_rptr_q <= !oq_rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_read_q <= p1_read_d;
    p1_ok_q   <= p1_ok_d;
    p1_addr_q <= p1_addr_d;
    lw_addr_q <= lw_addr_d;
    lw_data_q <= lw_data_d;
    if (oq_push) begin
      oq_q[oq_wptr_q] <= oq_push_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pph_checker.sv =====
`default_nettype none

module pph_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);
  import pph_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A result waiting for the receiver stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // A clear blocks the input while the store is swept.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == REQ_CLEAR) |=> !s_axis_tready)
    else $error("input ready right after a clear");

  // The output queue only fills from a read that has passed the write-back stage.
  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_acc && (s_axis_tuser == REQ_READ), 2))
    else $error("result without a read request");

  // A saturated counter can never read as zero.
  a_sat_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata != 24'd0))
    else $error("saturated flag on a zero count");

endmodule

bind per_plane_pixel_histogram_core pph_checker u_pph_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pph_pkg::*;

  // The block is built with its default plane count and counter width.
  localparam int TB_PLANES     = PLANES_DEF;
  localparam int TB_COUNT_BITS = COUNT_BITS_DEF;

  localparam logic [TB_COUNT_BITS-1:0] COUNT_MAX = '1;

  // Request code 3 has no meaning and must be ignored.
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

  // Quiet-cycle limit: the longest correct quiet stretch is a clearing pass
  // or the long receiver hold, so this is well above.
  localparam int QUIET_LIMIT  = 5000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 496;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  per_plane_pixel_histogram_core #(
    .PLANES    (TB_PLANES),
    .COUNT_BITS(TB_COUNT_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Directed stimulus. Where known is set, the read result is fixed by the
  // row itself; otherwise it comes from the histogram predictor.
  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [PLANE_W-1:0] plane;
    logic [LEVEL_W-1:0] level;
    logic               known;
    out_item_t          res;
  } dir_row_t;

  dir_row_t dir_rows [24] = '{
    '{REQ_READ,    2'd0, 8'd0,   1'b1, '{1'b0, 24'd0}},  // empty after reset
    '{REQ_READ,    2'd2, 8'd255, 1'b1, '{1'b0, 24'd0}},
    '{REQ_READ,    2'd3, 8'd255, 1'b1, '{1'b0, 24'd0}},  // highest plane, top bin
    '{REQ_COUNT,   2'd0, 8'd0,   1'b0, '{1'b0, 24'd0}},
    '{REQ_COUNT,   2'd0, 8'd0,   1'b0, '{1'b0, 24'd0}},  // back to back, same bin
    '{REQ_COUNT,   2'd2, 8'd255, 1'b0, '{1'b0, 24'd0}},
    '{REQ_COUNT,   2'd3, 8'd255, 1'b0, '{1'b0, 24'd0}},  // highest plane, top bin
    '{REQ_IGNORED, 2'd1, 8'd170, 1'b0, '{1'b0, 24'd0}},  // unused request code
    '{REQ_READ,    2'd0, 8'd0,   1'b0, '{1'b0, 24'd0}},
    '{REQ_READ,    2'd2, 8'd255, 1'b0, '{1'b0, 24'd0}},
    '{REQ_READ,    2'd3, 8'd255, 1'b0, '{1'b0, 24'd0}},
    '{REQ_COUNT,   2'd1, 8'd85,  1'b0, '{1'b0, 24'd0}},
    '{REQ_COUNT,   2'd1, 8'd170, 1'b0, '{1'b0, 24'd0}},
    '{REQ_READ,    2'd1, 8'd85,  1'b0, '{1'b0, 24'd0}},
    '{REQ_READ,    2'd1, 8'd170, 1'b0, '{1'b0, 24'd0}},
    '{REQ_CLEAR,   2'd0, 8'd0,   1'b0, '{1'b0, 24'd0}},
    '{REQ_READ,    2'd0, 8'd0,   1'b1, '{1'b0, 24'd0}},  // empty after clear
    '{REQ_READ,    2'd2, 8'd255, 1'b1, '{1'b0, 24'd0}},
    '{REQ_COUNT,   2'd2, 8'd255, 1'b0, '{1'b0, 24'd0}},  // first count after clear
    '{REQ_READ,    2'd2, 8'd255, 1'b0, '{1'b0, 24'd0}},
    '{REQ_CLEAR,   2'd3, 8'd255, 1'b0, '{1'b0, 24'd0}},  // clear with fields set
    '{REQ_READ,    2'd1, 8'd170, 1'b1, '{1'b0, 24'd0}},
    '{REQ_COUNT,   2'd1, 8'd1,   1'b0, '{1'b0, 24'd0}},
    '{REQ_READ,    2'd1, 8'd1,   1'b0, '{1'b0, 24'd0}}   // read right behind a count
  };

  logic [TB_COUNT_BITS-1:0] hist_bins [TB_PLANES*BINS];
  out_item_t                pending_reads [$];

  int unsigned mismatches  = 0;
  int unsigned src_idle    = 22;
  int unsigned rcv_idle    = 80;
  int unsigned hold_asks   = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned quiet       = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Applies one accepted beat to the local histogram; returns 1 with the
  // expected read result when the beat is a read.
  function automatic bit histogram_step(input logic [REQ_W-1:0] req,
                                        input logic [PLANE_W-1:0] plane,
                                        input logic [LEVEL_W-1:0] level,
                                        output out_item_t res);
    bit                       plane_ok;
    int unsigned              idx;
    logic [TB_COUNT_BITS-1:0] cur;
    plane_ok = plane < TB_PLANES;
    idx      = plane * BINS + level;
    res      = '0;
    histogram_step = 1'b0;
    case (req)
      REQ_COUNT: begin
        // A full counter stays where it is.
        if (plane_ok && hist_bins[idx] != COUNT_MAX) hist_bins[idx] = hist_bins[idx] + 1'b1;
      end
      REQ_READ: begin
        cur = plane_ok ? hist_bins[idx] : '0;
        res.bin_count = cur;
        res.saturated = plane_ok && (cur == COUNT_MAX);
        histogram_step = 1'b1;
      end
      REQ_CLEAR: begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
      end
      default: ;
    endcase
  endfunction

  // Offers one beat, with random gaps in front, and waits for it to be taken.
  task automatic send_beat(input logic [REQ_W-1:0] req, input logic [PLANE_W-1:0] plane,
                           input logic [LEVEL_W-1:0] level, input bit known,
                           input out_item_t known_res);
    out_item_t res;
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {6'd0, level, plane};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (histogram_step(req, plane, level, res)) pending_reads.push_back(known ? known_res : res);
  endtask

  // One phase of random traffic. Most counts go to a single hot bin so that
  // its count climbs well above the rest and same-bin beats come back to back.
  task automatic random_phase(input int unsigned n_items);
    logic [PLANE_W-1:0] hot_plane;
    logic [LEVEL_W-1:0] hot_level;
    logic [REQ_W-1:0]   req;
    logic [PLANE_W-1:0] plane;
    logic [LEVEL_W-1:0] level;
    int unsigned        done_items;
    int unsigned        pick;
    hot_plane = PLANE_W'($urandom_range(0, TB_PLANES - 1));
    hot_level = LEVEL_W'($urandom);
    send_beat(REQ_CLEAR, PLANE_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
    done_items = 1;
    while (done_items < n_items) begin
      pick  = $urandom_range(0, 99);
      plane = PLANE_W'($urandom);
      level = LEVEL_W'($urandom);
      if (pick < 3) begin
        req = REQ_IGNORED;
      end else if (pick < 25) begin
        req = REQ_READ;
        if ($urandom_range(0, 99) < 40) begin
          plane = hot_plane;
          level = hot_level;
        end
      end else begin
        req = REQ_COUNT;
        if ($urandom_range(0, 99) < 80) begin
          plane = hot_plane;
          level = hot_level;
        end
      end
      send_beat(req, plane, level, 1'b0, '0);
      if (req != REQ_IGNORED) done_items++;
    end
  endtask

  // Receiver: checks each read result against the oldest expectation and
  // drives tready, including the long hold used to back up the block.
  initial begin
    out_item_t want;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("read result with nothing pending, bin_count", m_axis_tdata, 0);
        end else begin
          want = pending_reads.pop_front();
          if (m_axis_tdata !== want.bin_count)
            report_mismatch("bin_count", m_axis_tdata, want.bin_count);
          if (m_axis_tuser[0] !== want.saturated)
            report_mismatch("saturated", m_axis_tuser[0], want.saturated);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left   = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  // Watchdog: ends the run when neither side moves a beat for too long.
  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("[per_plane_pixel_histogram_core] ERROR");
    $finish;
  end

  initial begin
    foreach (hist_bins[i]) hist_bins[i] = '0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block runs its clearing pass after reset; tready covers that.
    foreach (dir_rows[i])
      send_beat(dir_rows[i].req, dir_rows[i].plane, dir_rows[i].level, dir_rows[i].known,
                dir_rows[i].res);
    random_phase(PHASE_ITEMS);

    src_idle = 80;
    rcv_idle = 22;
    random_phase(PHASE_ITEMS);

    // No idling from here on. The receiver first holds off for a long
    // stretch while reads keep coming, so the output queue fills and the
    // block stalls its input.
    src_idle = 0;
    rcv_idle = 0;
    hold_asks++;
    for (int i = 0; i < 40; i++)
      send_beat(REQ_READ, PLANE_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
    random_phase(PHASE_ITEMS);

    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[per_plane_pixel_histogram_core] OK");
    end else begin
      $display("[per_plane_pixel_histogram_core] ERROR");
    end
    $finish;
  end

endmodule
